/* sv/bfhr_pkg.sv */
// Package: shared types, constants and helpers for the box filter Hessian response block
`timescale 1ns / 1ps
`default_nettype none

package bfhr_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int CW    = 11;   // internal coordinate width
    localparam int SW    = 26;   // integral store entry
    localparam int RSW   = 17;   // row running sum
    localparam int BOXW  = 20;   // capped box sum
    localparam int DW    = 23;   // derivative accumulators
    localparam int OW    = 21;   // derivative outputs
    localparam int RESPW = 48;
    localparam int MULA  = 46;
    localparam int MULB  = 24;
    localparam int PRODW = 60;
    localparam int NUMW  = 58;
    localparam int MAGW  = 57;
    localparam int DENW  = 31;
    localparam int QW    = 48;
    localparam int NREAD = 40;   // ten boxes, four corners each

    localparam logic [SW-1:0] BOX_CAP = 26'h00F_FFFF;
    localparam int W_NUM = 12996;
    localparam int W_DEN = 15625;

    localparam logic [9:0] RST_WIDTH  = 10'd512;
    localparam logic [9:0] RST_HEIGHT = 10'd512;
    localparam logic [6:0] RST_MASK   = 7'd9;
    localparam logic [4:0] RST_SCALE  = 5'd3;
    localparam logic [6:0] MASK_MIN   = 7'd9;
    localparam logic [6:0] MASK_MAX   = 7'd99;
    localparam logic [4:0] SCALE_MIN  = 5'd3;
    localparam logic [4:0] SCALE_MAX  = 5'd17;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_MASK,
        REG_SCALE
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LRD,
        S_LWR,
        S_QSET,
        S_QGEO,
        S_QRD,
        S_QDRN,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_M8,
        S_DST,
        S_DWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    // floor(s/3) for s below 128
    function automatic logic [5:0] div3(input logic [6:0] s);
        logic [14:0] p;
        p = 15'(s) * 15'd171;
        return p[14:9];
    endfunction

endpackage

`default_nettype wire

/* sv/box_filter_hessian_response.sv */
// Top level: box filter Hessian response with integral image store
// Usage:
//   Configuration goes through the APB-style port (width, height, mask, scale at
//   byte offsets 0, 4, 8, 12); write only while the block is idle. pready is tied high.
//   Input transactions (in_valid/in_ready) carry op, pixel, row, col. A load (op 0)
//   inside the frame updates the running row sum and writes one integral store
//   entry; it gives no result. A query (op 1) gives one output transaction.
//   A query in region runs setup, reads every box corner through the single read
//   port, uses the shared multiplier and the bit-serial divider, then hands the
//   result off. A query out of region skips the reads, multiplier and divider and returns zeros.
//   in_ready is high only while the sequencer is idle; one transaction at a time.
//   Results sit in an output register; the next transaction is accepted while a
//   result waits, and a later query holds in its last state until the output register is free.
//   Reset clears configuration to 512 x 512, mask 9, scale 3 and the row sum.
//   The store is not cleared: queries must touch only loaded entries.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_hessian_response
    import bfhr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    op,
    input  wire logic [7:0]              pixel,
    input  wire logic [8:0]              row,
    input  wire logic [8:0]              col,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [RESPW-1:0]      response,
    output logic signed [OW-1:0]         dxx_value,
    output logic signed [OW-1:0]         dyy_value,
    output logic signed [OW-1:0]         dxy_value,
    output logic                         in_region
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int AXW   = AW + CW;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] y, input logic [CW-1:0] x);
        logic [AXW-1:0] a;
        a = AXW'(y) * AXW'(MAX_WIDTH) + AXW'(x);
        return a[AW-1:0];
    endfunction

    // ---------------- registers ----------------
    state_t state_reg, state_next;

    logic [9:0] width_reg, width_next;
    logic [9:0] height_reg, height_next;
    logic [6:0] mask_reg, mask_next;
    logic [4:0] scale_reg, scale_next;

    logic [8:0]     row_reg, row_next;
    logic [8:0]     col_reg, col_next;
    logic [7:0]     pix_reg, pix_next;
    logic [RSW-1:0] rowsum_reg, rowsum_next;

    logic [6:0] s_reg, s_next;
    logic [4:0] l_reg, l_next;
    logic [5:0] t_reg, t_next;
    logic [5:0] mid_reg, mid_next;
    logic       region_reg, region_next;

    logic [CW-1:0] im1_reg, im1_next, jm1_reg, jm1_next;
    logic [CW-1:0] ioff_reg, ioff_next, ioffw_reg, ioffw_next;
    logic [CW-1:0] joff_reg, joff_next, joffw_reg, joffw_next;
    logic [CW-1:0] rm1_reg, rm1_next, rm1t_reg, rm1t_next;
    logic [CW-1:0] cm1_reg, cm1_next, cm1t_reg, cm1t_next;
    logic [CW-1:0] rt_reg, rt_next, ct_reg, ct_next;
    logic [CW-1:0] t2_reg, t2_next, t3_reg, t3_next;

    logic [5:0]       cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [5:0]       rd_idx_reg, rd_idx_next;
    logic [SW-1:0]    bacc_reg, bacc_next;
    logic signed [DW-1:0] dxx_reg, dxx_next, dyy_reg, dyy_next, dxy_reg, dxy_next;
    logic [DENW-1:0]  den_reg, den_next;
    logic signed [NUMW-1:0] num_reg, num_next;
    logic             neg_reg, neg_next;

    logic [RESPW-1:0] resp_out_reg, resp_out_next;
    logic [OW-1:0]    dxx_out_reg, dxx_out_next, dyy_out_reg, dyy_out_next;
    logic [OW-1:0]    dxy_out_reg, dxy_out_next;
    logic             region_out_reg, region_out_next;
    logic             out_valid_reg, out_valid_next;

    // ---------------- shared units ----------------
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [SW-1:0]           ram_wdata, ram_rdata;
    logic signed [MULA-1:0]  mul_a;
    logic signed [MULB-1:0]  mul_b;
    logic signed [PRODW-1:0] prod;
    logic                    div_start;
    logic [MAGW-1:0]         div_mag;
    div_stat_t               div_stat;
    logic [QW-1:0]           div_quo;

    bfhr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfhr_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    bfhr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // ---------------- config port ----------------
    logic apb_wr;
    reg_idx_t apb_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign apb_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mask_next   = mask_reg;
        scale_next  = scale_reg;
        if (apb_wr)
        begin
            unique case (apb_idx)
                REG_WIDTH:  width_next  = pwdata[9:0];
                REG_HEIGHT: height_next = pwdata[9:0];
                REG_MASK:   mask_next   = pwdata[6:0];
                REG_SCALE:  scale_next  = pwdata[4:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (apb_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_MASK:   prdata = 32'(mask_reg);
            REG_SCALE:  prdata = 32'(scale_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- effective sizes ----------------
    logic [9:0] eff_w, eff_h;
    logic       load_in_frame;

    assign eff_w = (13'(width_reg) < 13'(MAX_WIDTH)) ? width_reg : 10'(MAX_WIDTH);
    assign eff_h = (13'(height_reg) < 13'(MAX_HEIGHT)) ? height_reg : 10'(MAX_HEIGHT);
    assign load_in_frame = ({1'b0, row} < eff_h) && ({1'b0, col} < eff_w);

    // ---------------- query geometry ----------------
    logic [6:0]        s_sat;
    logic signed [12:0] gi, gj, hi_r, hi_c;
    logic [6:0]        gw, goff;
    logic [CW-1:0]     rr, cc, tt;

    assign s_sat = (mask_reg < MASK_MIN) ? MASK_MIN : ((mask_reg > MASK_MAX) ? MASK_MAX : mask_reg);
    assign rr    = CW'(row_reg);
    assign cc    = CW'(col_reg);
    assign tt    = CW'(t_reg);
    assign gi    = $signed(13'(row_reg)) - $signed(13'(mid_reg));
    assign gj    = $signed(13'(col_reg)) - $signed(13'(mid_reg));
    assign hi_r  = $signed(13'(eff_h)) - $signed(13'(s_reg)) - 13'sd1;
    assign hi_c  = $signed(13'(eff_w)) - $signed(13'(s_reg)) - 13'sd1;
    assign gw    = {t_reg, 1'b0} - 7'd1;
    assign goff  = ((s_reg - gw) >> 1) - 7'd1;

    // box corners for the read being issued
    logic [3:0]    qbox;
    logic [1:0]    qcor;
    logic [CW-1:0] by0, bx0, by1, bx1, qy, qx;

    assign qbox = cnt_reg[5:2];
    assign qcor = cnt_reg[1:0];

    always_comb
    begin
        case (qbox)
            4'd0:    begin by0 = im1_reg;          by1 = im1_reg + tt;
                           bx0 = joff_reg;         bx1 = joffw_reg; end
            4'd1:    begin by0 = im1_reg + tt;     by1 = im1_reg + t2_reg;
                           bx0 = joff_reg;         bx1 = joffw_reg; end
            4'd2:    begin by0 = im1_reg + t2_reg; by1 = im1_reg + t3_reg;
                           bx0 = joff_reg;         bx1 = joffw_reg; end
            4'd3:    begin by0 = ioff_reg;         by1 = ioffw_reg;
                           bx0 = jm1_reg;          bx1 = jm1_reg + tt; end
            4'd4:    begin by0 = ioff_reg;         by1 = ioffw_reg;
                           bx0 = jm1_reg + tt;     bx1 = jm1_reg + t2_reg; end
            4'd5:    begin by0 = ioff_reg;         by1 = ioffw_reg;
                           bx0 = jm1_reg + t2_reg; bx1 = jm1_reg + t3_reg; end
            4'd6:    begin by0 = rm1t_reg; bx0 = cm1t_reg; by1 = rm1_reg; bx1 = cm1_reg; end
            4'd7:    begin by0 = rm1t_reg; bx0 = cc;       by1 = rm1_reg; bx1 = ct_reg;  end
            4'd8:    begin by0 = rr;       bx0 = cc;       by1 = rt_reg;  bx1 = ct_reg;  end
            4'd9:    begin by0 = rr;       bx0 = cm1t_reg; by1 = rt_reg;  bx1 = cm1_reg; end
            default: begin by0 = '0; bx0 = '0; by1 = '0; bx1 = '0; end
        endcase
        case (qcor)
            2'd0:    begin qy = by1; qx = bx1; end
            2'd1:    begin qy = by1; qx = bx0; end
            2'd2:    begin qy = by0; qx = bx1; end
            default: begin qy = by0; qx = bx0; end
        endcase
    end

    // ---------------- accumulation of returned reads ----------------
    logic [3:0]      abox;
    logic [1:0]      acor;
    logic [SW-1:0]   bsum;
    logic [BOXW-1:0] bval;
    logic signed [DW-1:0] bpos, bneg2;

    assign abox  = rd_idx_reg[5:2];
    assign acor  = rd_idx_reg[1:0];
    assign bsum  = bacc_reg + ram_rdata;
    assign bval  = (bsum > BOX_CAP) ? BOX_CAP[BOXW-1:0] : bsum[BOXW-1:0];
    assign bpos  = $signed(DW'(bval));
    assign bneg2 = -$signed(DW'({bval, 1'b0}));

    // ---------------- result formatting ----------------
    logic [RESPW-1:0] resp_fmt;
    logic [OW-1:0]    dxx_sat, dyy_sat, dxy_sat;

    function automatic logic [OW-1:0] sat_d(input logic signed [DW-1:0] v);
        if (v > $signed(DW'(21'h0F_FFFF)))
        begin
            return 21'h0F_FFFF;
        end
        else if (v < -$signed(DW'(22'h10_0000)))
        begin
            return 21'h10_0000;
        end
        return v[OW-1:0];
    endfunction

    always_comb
    begin
        if (neg_reg)
        begin
            if (div_stat.ovf || (div_quo > 48'h8000_0000_0000))
            begin
                resp_fmt = 48'h8000_0000_0000;
            end
            else
            begin
                resp_fmt = -div_quo;
            end
        end
        else
        begin
            if (div_stat.ovf || div_quo[QW-1])
            begin
                resp_fmt = 48'h7FFF_FFFF_FFFF;
            end
            else
            begin
                resp_fmt = div_quo;
            end
        end
    end

    assign dxx_sat = sat_d(dxx_reg);
    assign dyy_sat = sat_d(dyy_reg);
    assign dxy_sat = sat_d(dxy_reg);
    assign div_mag = num_reg[NUMW-1] ? MAGW'(-num_reg) : MAGW'(num_reg);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_QUERY)
                    begin
                        state_next = S_QSET;
                    end
                    else if (load_in_frame)
                    begin
                        state_next = S_LRD;
                    end
                end
            end
            S_LRD:   state_next = S_LWR;
            S_LWR:   state_next = S_IDLE;
            S_QSET:  state_next = S_QGEO;
            S_QGEO:
            begin
                if (gi >= 13'sd1 && gi <= hi_r && gj >= 13'sd1 && gj <= hi_c)
                begin
                    state_next = S_QRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_QRD:
            begin
                if (cnt_reg == 6'(NREAD - 1))
                begin
                    state_next = S_QDRN;
                end
            end
            S_QDRN:  state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_M6;
            S_M6:    state_next = S_M7;
            S_M7:    state_next = S_M8;
            S_M8:    state_next = S_DST;
            S_DST:   state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- unit controls ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = addr_of(qy, qx);
        ram_waddr = addr_of(rr, cc);
        ram_wdata = ((row_reg == 9'd0) ? '0 : ram_rdata) + SW'(rowsum_reg);
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready  = 1'b1;
            S_LRD:   ram_raddr = addr_of(rr - CW'(1), cc);
            S_LWR:   ram_we    = 1'b1;
            S_M1:
            begin
                mul_a = MULA'(l_reg);
                mul_b = MULB'(l_reg);
            end
            S_M2:
            begin
                mul_a = prod[MULA-1:0];
                mul_b = prod[MULB-1:0];
            end
            S_M3:
            begin
                mul_a = MULA'(W_DEN);
                mul_b = prod[MULB-1:0];
            end
            S_M4:
            begin
                mul_a = MULA'(dxx_reg);
                mul_b = MULB'(dyy_reg);
            end
            S_M5:
            begin
                mul_a = prod[MULA-1:0];
                mul_b = MULB'(W_DEN);
            end
            S_M6:
            begin
                mul_a = MULA'(dxy_reg);
                mul_b = MULB'(dxy_reg);
            end
            S_M7:
            begin
                mul_a = prod[MULA-1:0];
                mul_b = MULB'(W_NUM);
            end
            S_DST:   div_start = 1'b1;
            default: in_ready  = 1'b0;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        pix_next     = pix_reg;
        rowsum_next  = rowsum_reg;
        s_next       = s_reg;
        l_next       = l_reg;
        t_next       = t_reg;
        mid_next     = mid_reg;
        region_next  = region_reg;
        im1_next     = im1_reg;
        jm1_next     = jm1_reg;
        ioff_next    = ioff_reg;
        ioffw_next   = ioffw_reg;
        joff_next    = joff_reg;
        joffw_next   = joffw_reg;
        rm1_next     = rm1_reg;
        rm1t_next    = rm1t_reg;
        cm1_next     = cm1_reg;
        cm1t_next    = cm1t_reg;
        rt_next      = rt_reg;
        ct_next      = ct_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        cnt_next     = cnt_reg;
        rd_pend_next = (state_reg == S_QRD);
        rd_idx_next  = cnt_reg;
        bacc_next    = bacc_reg;
        dxx_next     = dxx_reg;
        dyy_next     = dyy_reg;
        dxy_next     = dxy_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        neg_next     = neg_reg;
        resp_out_next   = resp_out_reg;
        dxx_out_next    = dxx_out_reg;
        dyy_out_next    = dyy_out_reg;
        dxy_out_next    = dxy_out_reg;
        region_out_next = region_out_reg;
        out_valid_next  = out_valid_reg & ~out_ready;

        if (state_reg == S_IDLE && in_valid)
        begin
            row_next = row;
            col_next = col;
            pix_next = pixel;
        end

        if (state_reg == S_LRD)
        begin
            rowsum_next = (col_reg == 9'd0) ? RSW'(pix_reg) : rowsum_reg + RSW'(pix_reg);
        end

        if (state_reg == S_QSET)
        begin
            s_next   = s_sat;
            l_next   = (scale_reg < SCALE_MIN) ? SCALE_MIN :
                       ((scale_reg > SCALE_MAX) ? SCALE_MAX : scale_reg);
            t_next   = div3(s_sat);
            mid_next = s_sat[6:1];
        end

        if (state_reg == S_QGEO)
        begin
            region_next = gi >= 13'sd1 && gi <= hi_r && gj >= 13'sd1 && gj <= hi_c;
            im1_next    = CW'(gi - 13'sd1);
            jm1_next    = CW'(gj - 13'sd1);
            ioff_next   = CW'(gi) + CW'(goff);
            ioffw_next  = CW'(gi) + CW'(goff) + CW'(gw);
            joff_next   = CW'(gj) + CW'(goff);
            joffw_next  = CW'(gj) + CW'(goff) + CW'(gw);
            rm1_next    = rr - CW'(1);
            rm1t_next   = rr - CW'(1) - tt;
            cm1_next    = cc - CW'(1);
            cm1t_next   = cc - CW'(1) - tt;
            rt_next     = rr + tt;
            ct_next     = cc + tt;
            t2_next     = {tt[CW-2:0], 1'b0};
            t3_next     = {tt[CW-2:0], 1'b0} + tt;
            cnt_next    = '0;
            dxx_next    = '0;
            dyy_next    = '0;
            dxy_next    = '0;
        end

        if (state_reg == S_QRD)
        begin
            cnt_next = cnt_reg + 6'd1;
        end

        if (rd_pend_reg)
        begin
            case (acor)
                2'd0:    bacc_next = ram_rdata;
                2'd1:    bacc_next = bacc_reg - ram_rdata;
                2'd2:    bacc_next = bacc_reg - ram_rdata;
                default:
                begin
                    case (abox)
                        4'd0, 4'd2: dyy_next = dyy_reg + bpos;
                        4'd1:       dyy_next = dyy_reg + bneg2;
                        4'd3, 4'd5: dxx_next = dxx_reg + bpos;
                        4'd4:       dxx_next = dxx_reg + bneg2;
                        4'd6, 4'd8: dxy_next = dxy_reg + bpos;
                        4'd7, 4'd9: dxy_next = dxy_reg - bpos;
                        default:    dxy_next = dxy_reg;
                    endcase
                end
            endcase
        end

        if (state_reg == S_M4)
        begin
            den_next = prod[DENW-1:0];
        end
        if (state_reg == S_M6)
        begin
            num_next = prod[NUMW-1:0];
        end
        if (state_reg == S_M8)
        begin
            num_next = num_reg - prod[NUMW-1:0];
        end
        if (state_reg == S_DST)
        begin
            neg_next = num_reg[NUMW-1];
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next  = 1'b1;
            region_out_next = region_reg;
            resp_out_next   = region_reg ? resp_fmt : '0;
            dxx_out_next    = region_reg ? dxx_sat : '0;
            dyy_out_next    = region_reg ? dyy_sat : '0;
            dxy_out_next    = region_reg ? dxy_sat : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            mask_reg      <= RST_MASK;
            scale_reg     <= RST_SCALE;
            rowsum_reg    <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            mask_reg      <= mask_next;
            scale_reg     <= scale_next;
            rowsum_reg    <= rowsum_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        pix_reg        <= pix_next;
        s_reg          <= s_next;
        l_reg          <= l_next;
        t_reg          <= t_next;
        mid_reg        <= mid_next;
        region_reg     <= region_next;
        im1_reg        <= im1_next;
        jm1_reg        <= jm1_next;
        ioff_reg       <= ioff_next;
        ioffw_reg      <= ioffw_next;
        joff_reg       <= joff_next;
        joffw_reg      <= joffw_next;
        rm1_reg        <= rm1_next;
        rm1t_reg       <= rm1t_next;
        cm1_reg        <= cm1_next;
        cm1t_reg       <= cm1t_next;
        rt_reg         <= rt_next;
        ct_reg         <= ct_next;
        t2_reg         <= t2_next;
        t3_reg         <= t3_next;
        rd_idx_reg     <= rd_idx_next;
        bacc_reg       <= bacc_next;
        dxx_reg        <= dxx_next;
        dyy_reg        <= dyy_next;
        dxy_reg        <= dxy_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        neg_reg        <= neg_next;
        resp_out_reg   <= resp_out_next;
        dxx_out_reg    <= dxx_out_next;
        dyy_out_reg    <= dyy_out_next;
        dxy_out_reg    <= dxy_out_next;
        region_out_reg <= region_out_next;
    end

    assign out_valid = out_valid_reg;
    assign response  = $signed(resp_out_reg);
    assign dxx_value = $signed(dxx_out_reg);
    assign dyy_value = $signed(dyy_out_reg);
    assign dxy_value = $signed(dxy_out_reg);
    assign in_region = region_out_reg;

    // ---------------- assertions ----------------
    a_rd_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == S_QRD))
        else $error("store read returned without an issue");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_LOAD) |=> !$rose(out_valid))
        else $error("load transaction produced a result");

endmodule

`default_nettype wire

/* sv/bfhr_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bfhr_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 262144
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/bfhr_mul.sv */
// Shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module bfhr_mul
    import bfhr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [MULA-1:0]  a,
    input  wire logic signed [MULB-1:0]  b,
    output logic signed      [PRODW-1:0] prod
);

    logic signed [MULA+MULB-1:0] full;
    logic signed [PRODW-1:0]     prod_next;
    logic signed [PRODW-1:0]     prod_reg;

    assign full      = a * b;
    assign prod_next = full[PRODW-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* sv/bfhr_div.sv */
// Radix-2 restoring divider: floor(mag * 2^16 / den), one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bfhr_div
    import bfhr_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [MAGW-1:0] mag,
    input  wire logic [DENW-1:0] den,
    output div_stat_t            stat,
    output logic      [QW-1:0]   quo
);

    localparam int CNTW = $clog2(QW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            ovf_reg, ovf_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [31:0]     rem_reg, rem_next;
    logic [QW-1:0]   dvd_reg, dvd_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [32:0]     trial;
    logic            ge;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign ge    = trial >= {2'b00, den};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            rem_next  = 32'(mag[MAGW-1:32]);
            dvd_next  = {mag[31:0], 16'h0000};
            ovf_next  = DENW'(mag[MAGW-1:32]) >= den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {2'b00, den}) : trial[31:0];
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

/* bench/tb_box_filter_hessian_response.sv */
// Testbench for box_filter_hessian_response: frame loads, queries and a scoreboard
`timescale 1ns / 1ps

module tb_box_filter_hessian_response;
    import bfhr_pkg::*;

    localparam int DIM = 512;
    localparam longint LIMIT = 4000000;

    typedef struct {
        logic [47:0] resp;
        logic [20:0] dxx;
        logic [20:0] dyy;
        logic [20:0] dxy;
        logic        inr;
    } hess_t;

    class hessian_scoreboard;
        logic [25:0] integral [DIM*DIM];
        logic [16:0] row_sum;
        logic [9:0]  img_w, img_h;
        logic [6:0]  mask_reg;
        logic [4:0]  scale_reg;
        hess_t       pending_q [$];
        int          errors;

        function new();
            row_sum = '0;
            img_w = RST_WIDTH;
            img_h = RST_HEIGHT;
            mask_reg = RST_MASK;
            scale_reg = RST_SCALE;
            errors = 0;
        endfunction

        function int frame_w();
            return (img_w < DIM) ? int'(img_w) : DIM;
        endfunction

        function int frame_h();
            return (img_h < DIM) ? int'(img_h) : DIM;
        endfunction

        function int side();
            return (mask_reg < MASK_MIN) ? int'(MASK_MIN) :
                   (mask_reg > MASK_MAX) ? int'(MASK_MAX) : int'(mask_reg);
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_WIDTH:  img_w = v[9:0];
                REG_HEIGHT: img_h = v[9:0];
                REG_MASK:   mask_reg = v[6:0];
                default:    scale_reg = v[4:0];
            endcase
        endfunction

        function logic [31:0] fetch(longint y, longint x);
            if (y < 0 || x < 0 || y >= DIM || x >= DIM)
                return 0;
            return {6'b0, integral[y*DIM + x]};
        endfunction

        function longint box_sum(longint y0, longint x0, longint y1, longint x1);
            logic [31:0] v;
            v = fetch(y1, x1) - fetch(y1, x0) - fetch(y0, x1) + fetch(y0, x0);
            v = v & 32'h3FF_FFFF;
            if (v > 32'(BOX_CAP))
                v = 32'(BOX_CAP);
            return longint'(v);
        endfunction

        function logic [20:0] clip21(longint v);
            if (v > 1048575) v = 1048575;
            if (v < -1048576) v = -1048576;
            return v[20:0];
        endfunction

        function void note(logic o, logic [7:0] px, logic [8:0] r, logic [8:0] c);
            longint hh, ww, s, lsc, mid, t, w, off, i, j, ri, ci;
            longint dxx, dyy, dxy, num;
            longint unsigned mag, den, q, rm, res;
            logic [31:0] above;
            hess_t e;
            hh = frame_h();
            ww = frame_w();
            ri = r;
            ci = c;
            if (o == OP_LOAD) begin
                if (ri >= hh || ci >= ww)
                    return;
                if (ci == 0)
                    row_sum = {9'b0, px};
                else
                    row_sum = row_sum + px;
                above = (ri == 0) ? 0 : fetch(ri - 1, ci);
                integral[ri*DIM + ci] = above[25:0] + {9'b0, row_sum};
                return;
            end
            s = side();
            lsc = (scale_reg < SCALE_MIN) ? 3 : (scale_reg > SCALE_MAX) ? 17 : scale_reg;
            mid = s / 2;
            t = s / 3;
            w = 2*t - 1;
            off = (s - w) / 2 - 1;
            i = ri - mid;
            j = ci - mid;
            e = '{default: '0};
            if (i >= 1 && i <= hh - s - 1 && j >= 1 && j <= ww - s - 1) begin
                dyy = box_sum(i-1, j+off, i+t-1, j+off+w)
                    - 2*box_sum(i+t-1, j+off, i+2*t-1, j+off+w)
                    + box_sum(i+2*t-1, j+off, i+3*t-1, j+off+w);
                dxx = box_sum(i+off, j-1, i+off+w, j+t-1)
                    - 2*box_sum(i+off, j+t-1, i+off+w, j+2*t-1)
                    + box_sum(i+off, j+2*t-1, i+off+w, j+3*t-1);
                dxy = box_sum(ri-1-t, ci-1-t, ri-1, ci-1)
                    - box_sum(ri-1-t, ci, ri-1, ci+t)
                    + box_sum(ri, ci, ri+t, ci+t)
                    - box_sum(ri, ci-1-t, ri+t, ci-1);
                num = dxx*dyy*W_DEN - longint'(W_NUM)*dxy*dxy;
                mag = (num < 0) ? longint'(-num) : num;
                den = longint'(W_DEN) * lsc*lsc*lsc*lsc;
                q = mag / den;
                rm = mag % den;
                res = q*65536 + (rm*65536) / den;
                if (num < 0) begin
                    if (res > 64'h8000_0000_0000)
                        res = 64'h8000_0000_0000;
                    res = -res;
                end else if (res > 64'h7FFF_FFFF_FFFF) begin
                    res = 64'h7FFF_FFFF_FFFF;
                end
                e.resp = res[47:0];
                e.dxx = clip21(dxx);
                e.dyy = clip21(dyy);
                e.dxy = clip21(dxy);
                e.inr = 1'b1;
            end
            pending_q = {pending_q, e};
        endfunction

        function void check(hess_t a);
            hess_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result resp=%h", a.resp);
                return;
            end
            e = pending_q.pop_front();
            if (a.resp !== e.resp || a.dxx !== e.dxx || a.dyy !== e.dyy ||
                a.dxy !== e.dxy || a.inr !== e.inr) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                             e.resp, e.dxx, e.dyy, e.dxy, e.inr,
                             a.resp, a.dxx, a.dyy, a.dxy, a.inr);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic op = 1'b0;
    logic [7:0] pixel = '0;
    logic [8:0] row = '0, col = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [RESPW-1:0] response;
    logic signed [OW-1:0] dxx_value, dyy_value, dxy_value;
    logic in_region;

    hessian_scoreboard sb = new();
    bit quiet = 1'b0;
    longint cycles = 0;

    box_filter_hessian_response dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check('{response, dxx_value, dyy_value, dxy_value, in_region});
        out_ready <= quiet || ($urandom_range(99) >= 25);
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic send(logic o, logic [7:0] px, logic [8:0] r, logic [8:0] c);
        if (!quiet && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        pixel <= px;
        row <= r;
        col <= c;
        do @(posedge clk); while (!in_ready);
        sb.note(o, px, r, c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_frame(int fill);
        logic [7:0] px;
        for (int r = 0; r < sb.frame_h(); r++)
            for (int c = 0; c < sb.frame_w(); c++) begin
                px = (fill == 1) ? 8'hFF : (fill == 2) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                                       : 8'($urandom);
                send(OP_LOAD, px, 9'(r), 9'(c));
            end
    endtask

    task automatic query_center(output logic [8:0] r, output logic [8:0] c);
        int s;
        s = sb.side();
        r = 9'($urandom_range(1, sb.frame_h() - s - 1) + s/2);
        c = 9'($urandom_range(1, sb.frame_w() - s - 1) + s/2);
    endtask

    task automatic run_phase(logic [31:0] w, logic [31:0] h, logic [31:0] m, logic [31:0] l,
                             int fill, int n);
        logic [8:0] r, c;
        int k;
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MASK, m);
        write_reg(REG_SCALE, l);
        load_frame(fill);
        for (int n_i = 0; n_i < n; n_i++) begin
            k = $urandom_range(99);
            if (k < 50) begin
                query_center(r, c);
                send(OP_QUERY, 8'($urandom), r, c);
            end else if (k < 72) begin
                send(OP_QUERY, 8'($urandom), 9'($urandom), 9'($urandom));
            end else if (k < 88) begin
                send(OP_LOAD, 8'($urandom), 9'($urandom_range(sb.frame_h() - 1)),
                     9'($urandom_range(sb.frame_w() - 1)));
            end else if (sb.frame_h() < DIM) begin
                send(OP_LOAD, 8'($urandom), 9'($urandom_range(DIM - 1, sb.frame_h())),
                     9'($urandom));
            end else if (sb.frame_w() < DIM) begin
                send(OP_LOAD, 8'($urandom), 9'($urandom),
                     9'($urandom_range(DIM - 1, sb.frame_w())));
            end else begin
                send(OP_QUERY, 8'($urandom), 9'($urandom), 9'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // reset geometry: only out-of-region queries, nothing loaded yet
        send(OP_QUERY, 8'hFF, 9'd0, 9'd0);
        send(OP_QUERY, 8'h00, 9'd511, 9'd511);
        drain();
        write_reg(REG_WIDTH, 16);
        write_reg(REG_HEIGHT, 16);
        write_reg(REG_MASK, 9);
        write_reg(REG_SCALE, 3);
        load_frame(1);
        send(OP_QUERY, 8'h00, 9'd5, 9'd5);
        send(OP_QUERY, 8'h00, 9'd10, 9'd10);
        send(OP_QUERY, 8'h00, 9'd5, 9'd10);
        send(OP_QUERY, 8'h00, 9'd4, 9'd5);
        send(OP_QUERY, 8'h00, 9'd11, 9'd10);
        send(OP_QUERY, 8'h00, 9'd5, 9'd511);
        send(OP_LOAD, 8'h00, 9'd7, 9'd8);
        send(OP_LOAD, 8'h55, 9'd511, 9'd3);
        send(OP_LOAD, 8'hAA, 9'd3, 9'd511);
        send(OP_QUERY, 8'h00, 9'd7, 9'd8);
        send(OP_QUERY, 8'h00, 9'd8, 9'd7);
        run_phase(16, 16, 0, 0, 0, 150);
        run_phase(20, 18, 10, 31, 0, 120);
        quiet = 1'b1;
        run_phase(16, 20, 13, 17, 2, 80);
        quiet = 1'b0;
        // oversized mask: every center falls outside the region
        drain();
        write_reg(REG_MASK, 127);
        write_reg(REG_SCALE, 31);
        for (int n_i = 0; n_i < 60; n_i++)
            send(OP_QUERY, 8'($urandom), 9'($urandom), 9'($urandom));
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
sv/bfhr_pkg.sv
sv/bfhr_ram.sv
sv/bfhr_mul.sv
sv/bfhr_div.sv
sv/box_filter_hessian_response.sv
bench/tb_box_filter_hessian_response.sv
